// File: rtl/permutation_distance_counter_unit_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef PERMUTATION_DISTANCE_COUNTER_UNIT_MACROS_SVH
`define PERMUTATION_DISTANCE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pdc_pkg.sv
package pdc_pkg;

    // Field widths
    localparam int CMD_W = 2;
    localparam int POS_W = 3;
    localparam int VAL_W = 8;
    localparam int LEN_W = 4;
    localparam int CNT_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_TARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    // Result of the shared magnitude compare
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

// File: rtl/permutation_distance_counter_unit.sv
// Permutation distance counter. Commands 0 and 1 write one start or target entry and
// never raise o_busy. Command 2 copies the start sequence into a working sequence and
// steps it through lexicographic next-permutation until it equals the target (count of
// permutations strictly between) or no ascent remains (count 0, found 0). A run keeps
// o_busy high through the copy, then for each permutation a load of the last entry, the
// ascent scan, the swap partner scan, the swap, a read, move and write-back step per
// swapped pair of the suffix reversal and the compare against the target; with fewer
// than two entries in use it answers without raising o_busy. The pace is set by the
// single read port of the working sequence and the one shared comparator. The result is
// a one-cycle beat on o_valid, rising as the block returns to idle, and is lost if not
// taken then: the receiver cannot stall the block.
module permutation_distance_counter_unit #(
    parameter int MAX_LEN = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pdc_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [pdc_pkg::CMD_W-1:0]  i_cmd,
    input  logic [pdc_pkg::POS_W-1:0]  i_position,
    input  logic [pdc_pkg::VAL_W-1:0]  i_entry_value,
    output logic                       o_valid,
    output logic [pdc_pkg::CNT_W-1:0]  o_between_count,
    output logic                       o_target_found
);
    import pdc_pkg::*;

    `include "permutation_distance_counter_unit_macros.svh"

    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_COPY  = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_SCANI = 10'b0000001000,
        S_SCANJ = 10'b0000010000,
        S_SWAP  = 10'b0000100000,
        S_REVRD = 10'b0001000000,
        S_REVMV = 10'b0010000000,
        S_REVWB = 10'b0100000000,
        S_CMP   = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len;
    logic [VAL_W-1:0]  r_st [MAX_LEN];
    logic [VAL_W-1:0]  r_tg [MAX_LEN];
    logic [VAL_W-1:0]  r_wk [MAX_LEN];
    logic [LW-1:0]     r_n;
    logic [IW-1:0]     r_idx, r_piv, r_lo, r_hi;
    logic [VAL_W-1:0]  r_hold, r_pivot, r_jval, r_tmp;
    logic [CNT_W-1:0]  r_count, r_res_count;
    logic              r_found, r_valid;

    logic              w_accept, w_pos_ok;
    logic [LW-1:0]     w_n_req;
    logic [IW-1:0]     w_last, w_rd_addr, w_lo_nx, w_hi_nx, w_piv_nx;
    logic [VAL_W-1:0]  w_rd, w_tg, w_cmp_a, w_cmp_b;
    t_cmp_res          w_cmp;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [VAL_W-1:0]  w_wdata;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_pos_ok = (32'(i_position) < MAX_LEN);
    assign o_busy   = (r_state != S_IDLE);

    // clamp the length register to 1..MAX_LEN
    always_comb begin
        if (r_len == '0) begin
            w_n_req = LW'(1);
        end else if (32'(r_len) > MAX_LEN) begin
            w_n_req = LW'(MAX_LEN);
        end else begin
            w_n_req = LW'(r_len);
        end
    end

    assign w_last   = IW'(r_n - 1'b1);
    assign w_lo_nx  = IW'(r_lo + 1'b1);
    assign w_hi_nx  = IW'(r_hi - 1'b1);
    assign w_piv_nx = IW'(r_piv + 1'b1);

    // single read port of the working sequence
    always_comb begin
        unique case (r_state)
            S_LOAD:  w_rd_addr = w_last;
            S_REVRD: w_rd_addr = r_lo;
            S_REVMV: w_rd_addr = r_hi;
            default: w_rd_addr = r_idx;
        endcase
    end
    assign w_rd = r_wk[w_rd_addr];
    assign w_tg = r_tg[r_idx];

    // operand select for the shared comparator
    always_comb begin
        unique case (r_state)
            S_SCANJ: begin
                w_cmp_a = r_pivot;
                w_cmp_b = w_rd;
            end
            S_CMP: begin
                w_cmp_a = w_rd;
                w_cmp_b = w_tg;
            end
            default: begin
                w_cmp_a = w_rd;
                w_cmp_b = r_hold;
            end
        endcase
    end

    pdc_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    // single write port of the working sequence
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_pivot;
        unique case (r_state)
            S_COPY: begin
                w_we    = 1'b1;
                w_wdata = r_st[r_idx];
            end
            S_SCANJ: begin
                w_we    = w_cmp.lt;
            end
            S_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_piv;
                w_wdata = r_jval;
            end
            S_REVMV: begin
                w_we    = 1'b1;
                w_waddr = r_lo;
                w_wdata = w_rd;
            end
            S_REVWB: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = r_tmp;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == CMD_RUN) && (32'(w_n_req) >= 2)) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (r_idx == w_last) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_SCANI;
            S_SCANI: begin
                if (w_cmp.lt) begin
                    n_state = S_SCANJ;
                end else if (r_idx == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_SCANJ: begin
                if (w_cmp.lt) n_state = S_SWAP;
            end
            S_SWAP:  n_state = (w_piv_nx < w_last) ? S_REVRD : S_CMP;
            S_REVRD: n_state = S_REVMV;
            S_REVMV: n_state = S_REVWB;
            S_REVWB: n_state = (w_lo_nx < w_hi_nx) ? S_REVRD : S_CMP;
            S_CMP: begin
                if (!w_cmp.eq) begin
                    n_state = S_LOAD;
                end else if (r_idx == w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (w_we) r_wk[w_waddr] <= w_wdata;
        if (w_accept && w_pos_ok) begin
            if (i_cmd == CMD_WR_START)  r_st[IW'(i_position)] <= i_entry_value;
            if (i_cmd == CMD_WR_TARGET) r_tg[IW'(i_position)] <= i_entry_value;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_RESET;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) r_len <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_cmd == CMD_RUN)) begin
                        r_n     <= w_n_req;
                        r_count <= '0;
                        r_idx   <= '0;
                        if (32'(w_n_req) < 2) begin
                            r_valid     <= 1'b1;
                            r_res_count <= '0;
                            r_found     <= 1'b0;
                        end
                    end
                end
                S_COPY: begin
                    r_idx <= IW'(r_idx + 1'b1);
                end
                S_LOAD: begin
                    r_hold <= w_rd;
                    r_idx  <= IW'(w_last - 1'b1);
                end
                S_SCANI: begin
                    if (w_cmp.lt) begin
                        r_piv   <= r_idx;
                        r_pivot <= w_rd;
                        r_idx   <= w_last;
                    end else begin
                        r_hold <= w_rd;
                        if (r_idx == '0) begin
                            // last permutation reached
                            r_valid     <= 1'b1;
                            r_res_count <= '0;
                            r_found     <= 1'b0;
                        end else begin
                            r_idx <= IW'(r_idx - 1'b1);
                        end
                    end
                end
                S_SCANJ: begin
                    if (w_cmp.lt) begin
                        r_jval <= w_rd;
                    end else begin
                        r_idx <= IW'(r_idx - 1'b1);
                    end
                end
                S_SWAP: begin
                    r_lo  <= w_piv_nx;
                    r_hi  <= w_last;
                    r_idx <= '0;
                end
                S_REVRD: begin
                    r_tmp <= w_rd;
                end
                S_REVMV: ;
                S_REVWB: begin
                    r_lo  <= w_lo_nx;
                    r_hi  <= w_hi_nx;
                    r_idx <= '0;
                end
                S_CMP: begin
                    if (!w_cmp.eq) begin
                        if (r_count != CNT_MAX) r_count <= r_count + 1'b1;
                    end else if (r_idx == w_last) begin
                        r_valid     <= 1'b1;
                        r_res_count <= r_count;
                        r_found     <= 1'b1;
                    end else begin
                        r_idx <= IW'(r_idx + 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_between_count = r_res_count;
    assign o_target_found  = r_found;

    // checks
    `PDC_ASSERT_NOW(a_beat_when_idle, o_valid, r_state == S_IDLE, "result beat while running")
    `PDC_ASSERT_NOW(a_miss_is_zero, o_valid && !o_target_found, o_between_count == '0,
        "nonzero count without target")
    `PDC_ASSERT_NEXT(a_run_responds, w_accept && (i_cmd == CMD_RUN), o_busy || o_valid,
        "run command neither started nor answered")
    `PDC_ASSERT_NEXT(a_write_silent, w_accept && (i_cmd != CMD_RUN), !o_valid,
        "result beat after a non-run command")
    `PDC_ASSERT_NOW(a_partner_right, r_state == S_SCANJ, r_idx > r_piv,
        "swap partner scan passed the pivot")

endmodule

// File: rtl/pdc_cmp.sv
module pdc_cmp (
    input  logic [pdc_pkg::VAL_W-1:0] i_a,
    input  logic [pdc_pkg::VAL_W-1:0] i_b,
    output pdc_pkg::t_cmp_res         o_res
);
    import pdc_pkg::*;

    logic [VAL_W:0] w_diff;

    // one subtractor gives both less-than (borrow) and equality
    assign w_diff    = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.lt  = w_diff[VAL_W];
    assign o_res.eq  = (w_diff[VAL_W-1:0] == '0);

endmodule
